[rtl/sbeq_pkg.sv]
// Shared types, widths, register indexes and reset values for the side button event qualifier.
package sbeq_pkg;

  // Beat widths on the two stream sides, padded to whole bytes.
  localparam int unsigned IN_TDATA_BITS  = 48;
  localparam int unsigned OUT_TDATA_BITS = 16;

  // Configuration port widths.
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = 16;

  // Field widths.
  localparam int unsigned NOW_BITS   = 32;
  localparam int unsigned EVENT_BITS = 8;
  localparam int unsigned MS_BITS    = 16;

  // Default parameter values.
  localparam int unsigned DEF_TIME_BITS      = 32;
  localparam int unsigned DEF_BOOT_EVENT_BIT = 0;
  localparam int unsigned DEF_PWR_EVENT_BIT  = 1;

  // Register reset values.
  localparam logic          PMU_PRESENT_RST    = 1'b1;
  localparam logic [15:0]   BOOT_HOLD_MS_RST   = 16'd45;
  localparam logic [15:0]   PMU_SCAN_MS_RST    = 16'd35;
  localparam logic [15:0]   CHARGE_SCAN_MS_RST = 16'd750;
  localparam logic [15:0]   EMIT_GAP_MS_RST    = 16'd350;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PMU_PRESENT    = 3'd0,
    REG_BOOT_HOLD_MS   = 3'd1,
    REG_PMU_SCAN_MS    = 3'd2,
    REG_CHARGE_SCAN_MS = 3'd3,
    REG_EMIT_GAP_MS    = 3'd4
  } cfg_reg_t;

  // One input beat, first field in the highest bits.
  typedef struct packed {
    logic                  hold_override_value;
    logic                  hold_override_valid;
    logic [EVENT_BITS-1:0] inject_events;
    logic                  charger_active;
    logic                  vbus_present;
    logic                  pek_short_irq;
    logic                  pek_rise_irq;
    logic                  pek_fall_irq;
    logic                  boot_pressed;
    logic [NOW_BITS-1:0]   now_ms;
  } poll_t;

  // One result beat, first field in the highest bits, zero padded.
  typedef struct packed {
    logic [3:0]            pad;
    logic                  irq_clear_request;
    logic                  irq_status_read;
    logic                  charging;
    logic                  ptt_held;
    logic [EVENT_BITS-1:0] events;
  } result_t;

endpackage

[rtl/side_button_event_qualifier.sv]
// Top level of the side button event qualifier: poll register, qualifying logic, result register.
//
// Each input beat is one poll of the buttons and power chip; each poll gives exactly one result
// beat. A poll is captured in an input register, qualified by one pass of subtract-and-compare
// logic against the stored timestamps, and written to the result register together with the
// updated state. The block takes one poll per clock cycle while results are taken at the output,
// and a result beat is offered on the output once its poll has passed through the input register
// and the result register. The state update is done by the combinational logic between the two
// registers. A result waiting at the output holds the next poll in the input
// register, so the input stalls only while both registers are full. All time differences wrap
// modulo 2^TIME_BITS. Configuration writes take effect at once and are meant for times when no
// poll is in flight.
module side_button_event_qualifier
  import sbeq_pkg::*;
#(
  parameter int unsigned TIME_BITS      = DEF_TIME_BITS,
  parameter int unsigned BOOT_EVENT_BIT = DEF_BOOT_EVENT_BIT,
  parameter int unsigned PWR_EVENT_BIT  = DEF_PWR_EVENT_BIT
) (
  input  logic                      clk,
  input  logic                      rst,
  // Poll stream.
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // Fields from bit 0 up: now_ms[31:0], boot_pressed, pek_fall_irq, pek_rise_irq,
  // pek_short_irq, vbus_present, charger_active, inject_events[7:0],
  // hold_override_valid, hold_override_value.
  input  logic [IN_TDATA_BITS-1:0]  s_tdata,
  // Result stream.
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // Fields from bit 0 up: events[7:0], ptt_held, charging, irq_status_read,
  // irq_clear_request, then zero padding.
  output logic [OUT_TDATA_BITS-1:0] m_tdata,
  // Configuration write port.
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wr_data
);

  localparam int unsigned WIDE_BITS = 64;

  // Event bit positions are taken modulo the event width.
  localparam logic [2:0] BOOT_POS = 3'(BOOT_EVENT_BIT % EVENT_BITS);
  localparam logic [2:0] PWR_POS  = 3'(PWR_EVENT_BIT % EVENT_BITS);

  // Configuration registers.
  logic               pmu_present;
  logic [MS_BITS-1:0] boot_hold_ms;
  logic [MS_BITS-1:0] pmu_scan_ms;
  logic [MS_BITS-1:0] charge_scan_ms;
  logic [MS_BITS-1:0] emit_gap_ms;

  // Qualifier state.
  logic                 boot_armed, boot_armed_next;
  logic                 boot_low_seen, boot_low_seen_next;
  logic [TIME_BITS-1:0] boot_low_time, boot_low_time_next;
  logic [TIME_BITS-1:0] last_key_scan, last_key_scan_next;
  logic [TIME_BITS-1:0] last_charge_sample, last_charge_sample_next;
  logic                 charge_first_done, charge_first_done_next;
  logic                 key_held_latch, key_held_latch_next;
  logic                 charging_flag, charging_flag_next;
  logic [TIME_BITS-1:0] last_emit_time, last_emit_time_next;

  // Pipeline registers.
  logic    poll_valid;
  poll_t   poll;
  logic    res_valid;
  result_t res;
  result_t res_next;

  logic poll_fire;

  // The input register moves on whenever the result register is free or being emptied.
  assign poll_fire = poll_valid && (!res_valid || m_tready);
  assign s_tready  = !poll_valid || poll_fire;
  assign m_tvalid  = res_valid;
  assign m_tdata   = res;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      pmu_present    <= PMU_PRESENT_RST;
      boot_hold_ms   <= BOOT_HOLD_MS_RST;
      pmu_scan_ms    <= PMU_SCAN_MS_RST;
      charge_scan_ms <= CHARGE_SCAN_MS_RST;
      emit_gap_ms    <= EMIT_GAP_MS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PMU_PRESENT:    pmu_present    <= cfg_wr_data[0];
        REG_BOOT_HOLD_MS:   boot_hold_ms   <= cfg_wr_data;
        REG_PMU_SCAN_MS:    pmu_scan_ms    <= cfg_wr_data;
        REG_CHARGE_SCAN_MS: charge_scan_ms <= cfg_wr_data;
        REG_EMIT_GAP_MS:    emit_gap_ms    <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_valid <= 1'b0;
    end else if (s_tready) begin
      poll_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      poll <= poll_t'(s_tdata);
    end
  end

  // Times and intervals brought to the timestamp width.
  logic [WIDE_BITS-1:0] now_wide;
  logic [TIME_BITS-1:0] now;
  logic [WIDE_BITS-1:0] boot_hold_wide, pmu_scan_wide, charge_scan_wide, emit_gap_wide;
  logic [TIME_BITS-1:0] boot_hold_t, pmu_scan_t, charge_scan_t, emit_gap_t;

  assign now_wide         = {{(WIDE_BITS-NOW_BITS){1'b0}}, poll.now_ms};
  assign now              = now_wide[TIME_BITS-1:0];
  assign boot_hold_wide   = {{(WIDE_BITS-MS_BITS){1'b0}}, boot_hold_ms};
  assign pmu_scan_wide    = {{(WIDE_BITS-MS_BITS){1'b0}}, pmu_scan_ms};
  assign charge_scan_wide = {{(WIDE_BITS-MS_BITS){1'b0}}, charge_scan_ms};
  assign emit_gap_wide    = {{(WIDE_BITS-MS_BITS){1'b0}}, emit_gap_ms};
  assign boot_hold_t      = boot_hold_wide[TIME_BITS-1:0];
  assign pmu_scan_t       = pmu_scan_wide[TIME_BITS-1:0];
  assign charge_scan_t    = charge_scan_wide[TIME_BITS-1:0];
  assign emit_gap_t       = emit_gap_wide[TIME_BITS-1:0];

  // Wrapping elapsed times since each stored timestamp.
  logic [TIME_BITS-1:0] boot_elapsed, key_elapsed, charge_elapsed, emit_elapsed;

  assign boot_elapsed   = now - boot_low_time;
  assign key_elapsed    = now - last_key_scan;
  assign charge_elapsed = now - last_charge_sample;
  assign emit_elapsed   = now - last_emit_time;

  // One pass of qualification for the poll in the input register.
  always_comb begin
    logic [EVENT_BITS-1:0] ev;
    logic                  scan;
    logic                  clear_req;
    logic                  latch;
    logic                  sample;

    ev        = poll.inject_events;
    clear_req = 1'b0;

    boot_armed_next         = boot_armed;
    boot_low_seen_next      = boot_low_seen;
    boot_low_time_next      = boot_low_time;
    last_key_scan_next      = last_key_scan;
    last_charge_sample_next = last_charge_sample;
    charge_first_done_next  = charge_first_done;
    charging_flag_next      = charging_flag;
    last_emit_time_next     = last_emit_time;

    // The override goes in first, so a scan in the same poll wins over it.
    latch = poll.hold_override_valid ? poll.hold_override_value : key_held_latch;

    // Boot button: the first pressed poll records its time, a later one may fire once.
    if (poll.boot_pressed) begin
      if (!boot_low_seen) begin
        boot_low_seen_next = 1'b1;
        boot_low_time_next = now;
      end else if (boot_armed && (boot_elapsed >= boot_hold_t)) begin
        boot_armed_next = 1'b0;
        ev[BOOT_POS]    = 1'b1;
      end
    end else begin
      boot_low_seen_next = 1'b0;
      boot_low_time_next = '0;
      boot_armed_next    = 1'b1;
    end

    // Power key IRQ scan, throttled; a rise beats a fall in the same scan.
    scan = pmu_present && (key_elapsed >= pmu_scan_t);
    if (scan) begin
      last_key_scan_next = now;
      if (poll.pek_rise_irq) begin
        latch = 1'b0;
      end else if (poll.pek_fall_irq) begin
        latch = 1'b1;
      end
      if (poll.pek_short_irq) begin
        ev[PWR_POS] = 1'b1;
      end
      clear_req = poll.pek_fall_irq || poll.pek_rise_irq || poll.pek_short_irq;
    end
    key_held_latch_next = latch;

    // Charging status; the first poll with the chip present always samples.
    sample = pmu_present && (!charge_first_done || (charge_elapsed >= charge_scan_t));
    if (!pmu_present) begin
      charging_flag_next = 1'b0;
    end else if (sample) begin
      last_charge_sample_next = now;
      charge_first_done_next  = 1'b1;
      charging_flag_next      = poll.vbus_present && poll.charger_active;
    end

    // Rate limit on nonzero event words.
    if (ev != '0) begin
      if (emit_elapsed < emit_gap_t) begin
        ev = '0;
      end else begin
        last_emit_time_next = now;
      end
    end

    res_next                   = '0;
    res_next.events            = ev;
    res_next.ptt_held          = pmu_present && latch;
    res_next.charging          = charging_flag_next;
    res_next.irq_status_read   = scan;
    res_next.irq_clear_request = clear_req;
  end

  // State update, one poll at a time as it passes into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      boot_armed         <= 1'b1;
      boot_low_seen      <= 1'b0;
      boot_low_time      <= '0;
      last_key_scan      <= '0;
      last_charge_sample <= '0;
      charge_first_done  <= 1'b0;
      key_held_latch     <= 1'b0;
      charging_flag      <= 1'b0;
      last_emit_time     <= '0;
    end else if (poll_fire) begin
      boot_armed         <= boot_armed_next;
      boot_low_seen      <= boot_low_seen_next;
      boot_low_time      <= boot_low_time_next;
      last_key_scan      <= last_key_scan_next;
      last_charge_sample <= last_charge_sample_next;
      charge_first_done  <= charge_first_done_next;
      key_held_latch     <= key_held_latch_next;
      charging_flag      <= charging_flag_next;
      last_emit_time     <= last_emit_time_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || m_tready) begin
      res_valid <= poll_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll_fire) begin
      res <= res_next;
    end
  end

endmodule
